// File: rtl/bssf_pkg.sv
// ----------------------------------------------------------------------------
// bssf_pkg
// Types and constants shared by the barometer sync and spike filter.
// ----------------------------------------------------------------------------
package bssf_pkg;

   localparam logic [1:0]  SPIKE_HOLD_FRAMES = 2'd3;
   localparam logic [15:0] SYNC_ERROR_MAX    = 16'hFFFF;
   localparam logic [15:0] NO_HISTORY        = 16'h0000;

   typedef struct packed {
      logic [15:0] pressure_in;
      logic [15:0] temperature_in;
   } req_type;

   typedef struct packed {
      logic [15:0] pressure_out;
      logic [15:0] temperature_out;
      logic        baro_valid;
      logic        spike_hold_active;
      logic [15:0] sync_error_total;
   } rsp_type;

   typedef struct packed {
      logic [15:0] previous_pressure;
      logic [15:0] previous_temperature;
      logic [15:0] good_pressure;
      logic [15:0] good_temperature;
      logic        expect_pressure_change;
      logic [1:0]  spike_countdown;
      logic        valid_flag;
      logic [15:0] sync_error_count;
   } filt_state_type;

   function automatic logic [15:0] abs_diff(input logic [15:0] a, input logic [15:0] b);
      abs_diff = (a > b) ? (a - b) : (b - a);
   endfunction

endpackage

// File: rtl/bssf_frame_check.sv
// ----------------------------------------------------------------------------
// bssf_frame_check
// Per-frame alternation check, swap test and spike hold; gives next state
// and the result transaction for one frame.
// ----------------------------------------------------------------------------
module bssf_frame_check
   import bssf_pkg::*;
(
   input  req_type        frame,
   input  filt_state_type state_cur,
   output filt_state_type state_nxt,
   output rsp_type        result
);

   logic [15:0] p;
   logic [15:0] t;
   logic        sync_err;
   logic        expect_nxt;
   logic        valid_nxt;
   logic [1:0]  countdown;
   logic        have_p;
   logic        have_t;

   assign p      = frame.pressure_in;
   assign t      = frame.temperature_in;
   assign have_p = (state_cur.previous_pressure != NO_HISTORY);
   assign have_t = (state_cur.previous_temperature != NO_HISTORY);

   always_comb begin
      sync_err   = 1'b0;
      valid_nxt  = state_cur.valid_flag;
      expect_nxt = 1'b0;
      if (!state_cur.expect_pressure_change) begin
         expect_nxt = 1'b1;
         if (have_p && (state_cur.previous_pressure != p)) begin
            expect_nxt = 1'b0;
            sync_err   = 1'b1;
         end
      end else begin
         if (have_t) begin
            if (state_cur.previous_temperature != t) begin
               expect_nxt = 1'b1;
               sync_err   = 1'b1;
            end else begin
               valid_nxt = 1'b1;
            end
         end
      end

      // words look swapped when closer to the other word's history
      if (have_p && have_t) begin
         if (abs_diff(state_cur.previous_pressure, p) >
             abs_diff(state_cur.previous_temperature, p))
            valid_nxt = 1'b0;
         if (abs_diff(state_cur.previous_temperature, t) >
             abs_diff(state_cur.previous_pressure, t))
            valid_nxt = 1'b0;
      end

      countdown = (p == t) ? SPIKE_HOLD_FRAMES : state_cur.spike_countdown;

      state_nxt                        = state_cur;
      state_nxt.previous_pressure      = p;
      state_nxt.previous_temperature   = t;
      state_nxt.expect_pressure_change = expect_nxt;
      if (sync_err && (state_cur.sync_error_count != SYNC_ERROR_MAX))
         state_nxt.sync_error_count = state_cur.sync_error_count + 16'd1;

      if (countdown != 2'd0) begin
         valid_nxt                 = 1'b0;
         state_nxt.spike_countdown = countdown - 2'd1;
         result.pressure_out       = state_cur.good_pressure;
         result.temperature_out    = state_cur.good_temperature;
         result.spike_hold_active  = 1'b1;
      end else begin
         state_nxt.spike_countdown  = 2'd0;
         state_nxt.good_pressure    = p;
         state_nxt.good_temperature = t;
         result.pressure_out        = p;
         result.temperature_out     = t;
         result.spike_hold_active   = 1'b0;
      end

      state_nxt.valid_flag    = valid_nxt;
      result.baro_valid       = valid_nxt;
      result.sync_error_total = state_nxt.sync_error_count;
   end

endmodule

// File: rtl/baro_sample_sync_spike_filter.sv
// ----------------------------------------------------------------------------
// baro_sample_sync_spike_filter
// Barometer frame alternation checker with swap detection and spike hold.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one barometer frame per transaction (pressure and
//   temperature words). rsp_* returns exactly one result per frame, in
//   order: passed-on or held words, validity flag, hold flag and the
//   saturating sync error count.
//   Two register stages: the frame is captured in an input register, the
//   check logic runs on it and loads the result register once that register
//   is empty or being read; rsp_valid then shows the result.
//   Throughput is one frame per cycle unless rsp_ready stalls; the filter
//   state updates as a frame moves from the input to the result register.
//   A stalled rsp_ready holds the result; the input register still takes
//   one more frame, then req_ready drops until the result is taken.
//   Reset clears both stage valids and all filter state (history words,
//   good pair, phase, hold countdown, validity and error count).
// ----------------------------------------------------------------------------
module baro_sample_sync_spike_filter
   import bssf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic           in_valid_ff;
   logic           in_valid_in;
   req_type        in_data_ff;
   logic           out_valid_ff;
   logic           out_valid_in;
   rsp_type        out_data_ff;
   filt_state_type state_ff;
   filt_state_type state_in;
   rsp_type        result;
   logic           out_take;
   logic           in_move;

   assign out_take  = !out_valid_ff || rsp_ready;
   assign in_move   = in_valid_ff && out_take;
   assign req_ready = !in_valid_ff || out_take;

   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !out_take);
   assign out_valid_in = in_move || (out_valid_ff && !rsp_ready);

   bssf_frame_check u_check (
      .frame     (in_data_ff),
      .state_cur (state_ff),
      .state_nxt (state_in),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (in_move)
            state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready)
         in_data_ff <= req_data;
      if (in_move)
         out_data_ff <= result;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

`ifndef SYNTHESIS
   a_hold_not_valid: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_data_ff.spike_hold_active |-> !out_data_ff.baro_valid)
      else $error("spike hold result flagged valid");

   a_err_count_monotonic: assert property (@(posedge clock) disable iff (reset)
      !reset |=> state_ff.sync_error_count >= $past(state_ff.sync_error_count))
      else $error("sync error count decreased");

   a_in_stage_holds: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_take |=> in_valid_ff && $stable(in_data_ff))
      else $error("stalled input stage lost its frame");

   a_state_only_on_move: assert property (@(posedge clock) disable iff (reset)
      !in_move |=> $stable(state_ff))
      else $error("filter state changed without a frame");
`endif

endmodule
